// ===== rtl/core/qsu_pkg.sv =====
`default_nettype none

package qsu_pkg;

    localparam int UCS_DIGITS = 6;
    localparam int DCNT_W     = $clog2(UCS_DIGITS + 1);
    localparam int ACC_W      = 24;
    localparam int MAX_RES    = 5;
    localparam int UTF_MAX    = 4;
    localparam int CNT_W      = $clog2(MAX_RES + 1);

    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_ESC   = 3'd1;
    localparam logic [2:0] MODE_OCT   = 3'd2;
    localparam logic [2:0] MODE_HEX   = 3'd3;
    localparam logic [2:0] MODE_UCS   = 3'd4;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_UNTERM = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OCTAL     = 2'd1;
    localparam logic [1:0] ERR_NO_DIGITS = 2'd2;
    localparam logic [1:0] ERR_RANGE     = 2'd3;

    localparam logic [DCNT_W-1:0] OCT_LIMIT = DCNT_W'(3);
    localparam logic [DCNT_W-1:0] HEX_LIMIT = DCNT_W'(2);
    localparam logic [DCNT_W-1:0] UCS_LIMIT = DCNT_W'(UCS_DIGITS);

    localparam logic [ACC_W-1:0] OCT_MAX = ACC_W'(255);
    localparam logic [ACC_W-1:0] CP_MAX  = ACC_W'(24'h10FFFF);

    typedef struct packed {
        logic [7:0] ch;
        logic       opens;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] error_code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] error_code;
    } entry_t;

    typedef struct packed {
        logic [2:0]               count;
        entry_t [UTF_MAX-1:0]     ent;
    } finish_t;

    function automatic entry_t make_entry(logic [7:0] b, logic [1:0] k, logic [1:0] e);
        entry_t r;
        r.out_byte   = b;
        r.kind       = k;
        r.error_code = e;
        return r;
    endfunction

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end
        else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end
        else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

    function automatic finish_t utf8_encode(logic [20:0] cp);
        finish_t f;
        f = '0;
        if (cp < 21'h80) begin
            f.count  = 3'd1;
            f.ent[0] = make_entry({1'b0, cp[6:0]}, KIND_DATA, ERR_NONE);
        end
        else if (cp < 21'h800) begin
            f.count  = 3'd2;
            f.ent[0] = make_entry({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
            f.ent[1] = make_entry({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
        end
        else if (cp < 21'h10000) begin
            f.count  = 3'd3;
            f.ent[0] = make_entry({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
            f.ent[1] = make_entry({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
            f.ent[2] = make_entry({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
        end
        else begin
            f.count  = 3'd4;
            f.ent[0] = make_entry({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
            f.ent[1] = make_entry({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
            f.ent[2] = make_entry({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
            f.ent[3] = make_entry({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
        end
        return f;
    endfunction

    // Closes a pending numeric escape and gives the results it causes.
    function automatic finish_t finish_number(logic [2:0] mode, logic [ACC_W-1:0] acc,
                                              logic [DCNT_W-1:0] dcnt);
        finish_t f;
        f = '0;
        unique case (mode)
            MODE_OCT:
            begin
                f.count = 3'd1;
                if (acc <= OCT_MAX) begin
                    f.ent[0] = make_entry(acc[7:0], KIND_DATA, ERR_NONE);
                end
                else begin
                    f.ent[0] = make_entry(8'd0, KIND_ERROR, ERR_OCTAL);
                end
            end
            MODE_HEX:
            begin
                f.count = 3'd1;
                if (dcnt == '0) begin
                    f.ent[0] = make_entry(8'd0, KIND_ERROR, ERR_NO_DIGITS);
                end
                else begin
                    f.ent[0] = make_entry(acc[7:0], KIND_DATA, ERR_NONE);
                end
            end
            MODE_UCS:
            begin
                if (dcnt == '0) begin
                    f.count  = 3'd1;
                    f.ent[0] = make_entry(8'd0, KIND_ERROR, ERR_NO_DIGITS);
                end
                else if (acc > CP_MAX) begin
                    f.count  = 3'd1;
                    f.ent[0] = make_entry(8'd0, KIND_ERROR, ERR_RANGE);
                end
                else begin
                    f = utf8_encode(acc[20:0]);
                end
            end
            default:
            begin
                f = '0;
            end
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/quoted_string_unescaper_core.sv =====
`default_nettype none

// Flow: a byte is registered on its transfer, decoded from that register, and its
// results are registered as the output bundle once the previous bundle has drained.
// Throughput: one byte per cycle while the output is not stalled and each byte gives at most
// one result; a byte with several results (up to five) stalls the input until all but its last drain.
// Reset clears the literal state and all valid flags; no result is pending after reset.
module quoted_string_unescaper_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output      logic               item_stall,
    input  wire qsu_pkg::item_t     item,
    output      logic               result_valid,
    input  wire logic               result_stall,
    output      qsu_pkg::result_t   result
);

    qsu_pkg::item_t                     in_reg;
    logic                               in_full_reg;
    logic                               in_full_next;

    logic                               active_reg;
    logic                               active_next;
    logic [7:0]                         closer_reg;
    logic [7:0]                         closer_next;
    logic [2:0]                         mode_reg;
    logic [2:0]                         mode_next;
    logic [qsu_pkg::ACC_W-1:0]          acc_reg;
    logic [qsu_pkg::ACC_W-1:0]          acc_next;
    logic [qsu_pkg::DCNT_W-1:0]         dcnt_reg;
    logic [qsu_pkg::DCNT_W-1:0]         dcnt_next;

    qsu_pkg::entry_t                    ents_reg  [qsu_pkg::MAX_RES];
    qsu_pkg::entry_t                    ents_next [qsu_pkg::MAX_RES];
    logic [qsu_pkg::CNT_W-1:0]          cnt_reg;
    logic [qsu_pkg::CNT_W-1:0]          cnt_next;

    qsu_pkg::entry_t                    new_ents  [qsu_pkg::MAX_RES];
    logic [qsu_pkg::CNT_W-1:0]          new_cnt;

    logic                               drain;
    logic                               bundle_free;
    logic                               advance;
    logic                               take;

    logic [7:0]                         c;
    logic                               is_oct;
    logic [4:0]                         hexd;
    logic [qsu_pkg::ACC_W-1:0]          oct_acc;
    logic [qsu_pkg::ACC_W-1:0]          hex_acc;
    logic [qsu_pkg::DCNT_W-1:0]         dinc;
    logic [qsu_pkg::DCNT_W-1:0]         limit;
    logic                               do_fin;
    logic [2:0]                         fmode;
    logic [qsu_pkg::ACC_W-1:0]          facc;
    logic [qsu_pkg::DCNT_W-1:0]         fdcnt;
    logic                               do_plain;
    logic                               tail_v;
    qsu_pkg::entry_t                    tail;
    qsu_pkg::finish_t                   fin;

    assign drain        = result_valid && !result_stall;
    assign bundle_free  = (cnt_reg == '0) || ((cnt_reg == qsu_pkg::CNT_W'(1)) && drain);
    assign advance      = in_full_reg && bundle_free;
    assign item_stall   = in_full_reg && !bundle_free;
    assign take         = item_valid && !item_stall;

    assign result_valid       = (cnt_reg != '0);
    assign result.out_byte    = ents_reg[0].out_byte;
    assign result.kind        = ents_reg[0].kind;
    assign result.error_code  = ents_reg[0].error_code;
    assign result.last        = (cnt_reg == qsu_pkg::CNT_W'(1));

    always_comb
    begin
        c        = in_reg.ch;
        is_oct   = (c >= "0") && (c <= "7");
        hexd     = qsu_pkg::hex_digit(c);
        oct_acc  = {acc_reg[qsu_pkg::ACC_W-4:0], c[2:0]};
        hex_acc  = (acc_reg[qsu_pkg::ACC_W-1:qsu_pkg::ACC_W-4] != '0) ? '1
                 : {acc_reg[qsu_pkg::ACC_W-5:0], hexd[3:0]};
        dinc     = dcnt_reg + qsu_pkg::DCNT_W'(1);
        limit    = (mode_reg == qsu_pkg::MODE_UCS) ? qsu_pkg::UCS_LIMIT : qsu_pkg::HEX_LIMIT;

        active_next = active_reg;
        closer_next = closer_reg;
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        dcnt_next   = dcnt_reg;
        do_fin      = 1'b0;
        fmode       = mode_reg;
        facc        = acc_reg;
        fdcnt       = dcnt_reg;
        do_plain    = 1'b0;
        tail_v      = 1'b0;
        tail        = '0;

        if (in_reg.end_of_text) begin
            if (active_reg) begin
                do_fin = (mode_reg >= qsu_pkg::MODE_OCT);
                tail_v = 1'b1;
                tail   = qsu_pkg::make_entry(8'd0, qsu_pkg::KIND_UNTERM, qsu_pkg::ERR_NONE);
            end
            active_next = 1'b0;
            mode_next   = qsu_pkg::MODE_PLAIN;
            acc_next    = '0;
            dcnt_next   = '0;
        end
        else if (!active_reg) begin
            if (in_reg.opens) begin
                active_next = 1'b1;
                closer_next = c;
                mode_next   = qsu_pkg::MODE_PLAIN;
                acc_next    = '0;
                dcnt_next   = '0;
            end
        end
        else begin
            unique case (mode_reg)
                qsu_pkg::MODE_ESC:
                begin
                    mode_next = qsu_pkg::MODE_PLAIN;
                    acc_next  = '0;
                    dcnt_next = '0;
                    tail_v    = 1'b1;
                    tail      = qsu_pkg::make_entry(c, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                    unique case (c)
                        "a": tail.out_byte = 8'h07;
                        "b": tail.out_byte = 8'h08;
                        "t": tail.out_byte = 8'h09;
                        "n": tail.out_byte = 8'h0A;
                        "v": tail.out_byte = 8'h0B;
                        "f": tail.out_byte = 8'h0C;
                        "x", "X":
                        begin
                            tail_v    = 1'b0;
                            mode_next = qsu_pkg::MODE_HEX;
                        end
                        "u", "U":
                        begin
                            tail_v    = 1'b0;
                            mode_next = qsu_pkg::MODE_UCS;
                        end
                        default:
                        begin
                            if (is_oct) begin
                                tail_v    = 1'b0;
                                mode_next = qsu_pkg::MODE_OCT;
                                acc_next  = qsu_pkg::ACC_W'(c[2:0]);
                                dcnt_next = qsu_pkg::DCNT_W'(1);
                            end
                        end
                    endcase
                end
                qsu_pkg::MODE_OCT:
                begin
                    if (is_oct) begin
                        if (dinc >= qsu_pkg::OCT_LIMIT) begin
                            do_fin    = 1'b1;
                            facc      = oct_acc;
                            fdcnt     = dinc;
                            mode_next = qsu_pkg::MODE_PLAIN;
                            acc_next  = '0;
                            dcnt_next = '0;
                        end
                        else begin
                            acc_next  = oct_acc;
                            dcnt_next = dinc;
                        end
                    end
                    else begin
                        do_fin    = 1'b1;
                        do_plain  = 1'b1;
                        mode_next = qsu_pkg::MODE_PLAIN;
                        acc_next  = '0;
                        dcnt_next = '0;
                    end
                end
                qsu_pkg::MODE_HEX, qsu_pkg::MODE_UCS:
                begin
                    if (hexd[4]) begin
                        if (dinc >= limit) begin
                            do_fin    = 1'b1;
                            facc      = hex_acc;
                            fdcnt     = dinc;
                            mode_next = qsu_pkg::MODE_PLAIN;
                            acc_next  = '0;
                            dcnt_next = '0;
                        end
                        else begin
                            acc_next  = hex_acc;
                            dcnt_next = dinc;
                        end
                    end
                    else begin
                        do_fin    = 1'b1;
                        do_plain  = 1'b1;
                        mode_next = qsu_pkg::MODE_PLAIN;
                        acc_next  = '0;
                        dcnt_next = '0;
                    end
                end
                default:
                begin
                    mode_next = qsu_pkg::MODE_PLAIN;
                    do_plain  = 1'b1;
                end
            endcase
        end

        if (do_plain) begin
            priority if (c == 8'h0A) begin
                tail_v      = 1'b1;
                tail        = qsu_pkg::make_entry(8'd0, qsu_pkg::KIND_UNTERM, qsu_pkg::ERR_NONE);
                active_next = 1'b0;
            end
            else if (c == "\\") begin
                mode_next = qsu_pkg::MODE_ESC;
            end
            else if (c == closer_reg) begin
                tail_v      = 1'b1;
                tail        = qsu_pkg::make_entry(8'd0, qsu_pkg::KIND_CLOSED, qsu_pkg::ERR_NONE);
                active_next = 1'b0;
            end
            else begin
                tail_v = 1'b1;
                tail   = qsu_pkg::make_entry(c, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
            end
        end

        fin = do_fin ? qsu_pkg::finish_number(fmode, facc, fdcnt) : '0;

        for (int i = 0; i < qsu_pkg::MAX_RES; i++) begin
            new_ents[i] = tail;
        end
        for (int i = 0; i < qsu_pkg::UTF_MAX; i++) begin
            if (3'(i) < fin.count) begin
                new_ents[i] = fin.ent[i];
            end
        end
        new_cnt = qsu_pkg::CNT_W'(fin.count) + qsu_pkg::CNT_W'(tail_v);
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (take) begin
            in_full_next = 1'b1;
        end
        else if (advance) begin
            in_full_next = 1'b0;
        end

        cnt_next = cnt_reg;
        for (int i = 0; i < qsu_pkg::MAX_RES; i++) begin
            ents_next[i] = ents_reg[i];
        end
        if (advance) begin
            cnt_next = new_cnt;
            for (int i = 0; i < qsu_pkg::MAX_RES; i++) begin
                ents_next[i] = new_ents[i];
            end
        end
        else if (drain) begin
            cnt_next = cnt_reg - qsu_pkg::CNT_W'(1);
            for (int i = 0; i < qsu_pkg::MAX_RES - 1; i++) begin
                ents_next[i] = ents_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
            cnt_reg     <= '0;
            active_reg  <= 1'b0;
            closer_reg  <= '0;
            mode_reg    <= qsu_pkg::MODE_PLAIN;
            acc_reg     <= '0;
            dcnt_reg    <= '0;
        end
        else begin
            in_full_reg <= in_full_next;
            cnt_reg     <= cnt_next;
            if (advance) begin
                active_reg <= active_next;
                closer_reg <= closer_next;
                mode_reg   <= mode_next;
                acc_reg    <= acc_next;
                dcnt_reg   <= dcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            in_reg <= item;
        end
        for (int i = 0; i < qsu_pkg::MAX_RES; i++) begin
            ents_reg[i] <= ents_next[i];
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_quoted_string_unescaper_core.sv =====
`default_nettype none

module tb_quoted_string_unescaper_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_ITEMS = 70;

    class unescape_scoreboard;
        bit                 active;
        bit [7:0]           closer;
        logic [2:0]         mode;
        bit [23:0]          acc;
        int unsigned        ndig;
        qsu_pkg::result_t   decoded_q[$];
        int unsigned        errors;

        function new();
            active = 1'b0;
            closer = 8'h00;
            mode   = qsu_pkg::MODE_PLAIN;
            acc    = '0;
            ndig   = 0;
            errors = 0;
        endfunction

        function void emit(bit [7:0] b, logic [1:0] k, logic [1:0] e);
            qsu_pkg::result_t r;
            r.out_byte   = b;
            r.kind       = k;
            r.error_code = e;
            r.last       = 1'b0;
            decoded_q.insert(decoded_q.size(), r);
        endfunction

        function void emit_code_point(bit [23:0] cp);
            if (cp < 24'h80)
            begin
                emit(cp[7:0], qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
            end
            else if (cp < 24'h800)
            begin
                emit(8'(24'hC0 | (cp >> 6)), qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                emit(8'(24'h80 | (cp & 24'h3F)), qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
            end
            else if (cp < 24'h10000)
            begin
                emit(8'(24'hE0 | (cp >> 12)), qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                emit(8'(24'h80 | ((cp >> 6) & 24'h3F)), qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                emit(8'(24'h80 | (cp & 24'h3F)), qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
            end
            else
            begin
                emit(8'(24'hF0 | (cp >> 18)), qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                emit(8'(24'h80 | ((cp >> 12) & 24'h3F)), qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                emit(8'(24'h80 | ((cp >> 6) & 24'h3F)), qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                emit(8'(24'h80 | (cp & 24'h3F)), qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
            end
        endfunction

        function void settle_escape();
            case (mode)
                qsu_pkg::MODE_OCT:
                begin
                    if (acc < 24'd256)
                        emit(acc[7:0], qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                    else
                        emit(8'h00, qsu_pkg::KIND_ERROR, qsu_pkg::ERR_OCTAL);
                end
                qsu_pkg::MODE_HEX:
                begin
                    if (ndig == 0)
                        emit(8'h00, qsu_pkg::KIND_ERROR, qsu_pkg::ERR_NO_DIGITS);
                    else
                        emit(acc[7:0], qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                end
                qsu_pkg::MODE_UCS:
                begin
                    if (ndig == 0)
                        emit(8'h00, qsu_pkg::KIND_ERROR, qsu_pkg::ERR_NO_DIGITS);
                    else if (acc > 24'h10FFFF)
                        emit(8'h00, qsu_pkg::KIND_ERROR, qsu_pkg::ERR_RANGE);
                    else
                        emit_code_point(acc);
                end
                default:
                begin
                end
            endcase
            mode = qsu_pkg::MODE_PLAIN;
            acc  = '0;
            ndig = 0;
        endfunction

        function void take_plain(bit [7:0] c);
            if (c == 8'h0A)
            begin
                emit(8'h00, qsu_pkg::KIND_UNTERM, qsu_pkg::ERR_NONE);
                active = 1'b0;
            end
            else if (c == 8'h5C)
            begin
                mode = qsu_pkg::MODE_ESC;
            end
            else if (c == closer)
            begin
                emit(8'h00, qsu_pkg::KIND_CLOSED, qsu_pkg::ERR_NONE);
                active = 1'b0;
            end
            else
            begin
                emit(c, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
            end
        endfunction

        function void take_escaped(bit [7:0] c);
            mode = qsu_pkg::MODE_PLAIN;
            acc  = '0;
            ndig = 0;
            case (c)
                "a": emit(8'h07, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                "b": emit(8'h08, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                "t": emit(8'h09, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                "n": emit(8'h0A, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                "v": emit(8'h0B, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                "f": emit(8'h0C, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                "x", "X": mode = qsu_pkg::MODE_HEX;
                "u", "U": mode = qsu_pkg::MODE_UCS;
                default:
                begin
                    if (c >= "0" && c <= "7")
                    begin
                        mode = qsu_pkg::MODE_OCT;
                        acc  = 24'(c - 8'h30);
                        ndig = 1;
                    end
                    else
                    begin
                        emit(c, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE);
                    end
                end
            endcase
        endfunction

        function int digit_of(bit [7:0] c);
            if (c >= "0" && c <= "9")
                return int'(c - 8'h30);
            if (c >= "a" && c <= "f")
                return int'(c - 8'h61) + 10;
            if (c >= "A" && c <= "F")
                return int'(c - 8'h41) + 10;
            return -1;
        endfunction

        function void note_transfer(qsu_pkg::item_t it);
            int unsigned before_n;
            int          d;
            bit [31:0]   v;
            int unsigned lim;
            before_n = decoded_q.size();
            if (it.end_of_text)
            begin
                if (active)
                begin
                    if (mode >= qsu_pkg::MODE_OCT)
                        settle_escape();
                    emit(8'h00, qsu_pkg::KIND_UNTERM, qsu_pkg::ERR_NONE);
                end
                active = 1'b0;
                mode   = qsu_pkg::MODE_PLAIN;
                acc    = '0;
                ndig   = 0;
            end
            else if (!active)
            begin
                if (it.opens)
                begin
                    active = 1'b1;
                    closer = it.ch;
                    mode   = qsu_pkg::MODE_PLAIN;
                    acc    = '0;
                    ndig   = 0;
                end
            end
            else if (mode == qsu_pkg::MODE_ESC)
            begin
                take_escaped(it.ch);
            end
            else if (mode == qsu_pkg::MODE_OCT)
            begin
                if (it.ch >= "0" && it.ch <= "7")
                begin
                    acc  = (acc << 3) | 24'(it.ch - 8'h30);
                    ndig = ndig + 1;
                    if (ndig >= 3)
                        settle_escape();
                end
                else
                begin
                    settle_escape();
                    take_plain(it.ch);
                end
            end
            else if (mode == qsu_pkg::MODE_HEX || mode == qsu_pkg::MODE_UCS)
            begin
                d   = digit_of(it.ch);
                lim = (mode == qsu_pkg::MODE_UCS) ? qsu_pkg::UCS_DIGITS : 2;
                if (d >= 0)
                begin
                    v    = 32'(acc) * 32'd16 + 32'(d);
                    acc  = (v > 32'hFFFFFF) ? 24'hFFFFFF : v[23:0];
                    ndig = ndig + 1;
                    if (ndig >= lim)
                        settle_escape();
                end
                else
                begin
                    settle_escape();
                    take_plain(it.ch);
                end
            end
            else
            begin
                mode = qsu_pkg::MODE_PLAIN;
                take_plain(it.ch);
            end
            if (decoded_q.size() > before_n)
                decoded_q[decoded_q.size() - 1].last = 1'b1;
        endfunction

        function void check_transfer(qsu_pkg::result_t got);
            qsu_pkg::result_t want;
            if (decoded_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result byte=%h kind=%0d err=%0d last=%0b",
                         $time, got.out_byte, got.kind, got.error_code, got.last);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch expected %h/%0d/%0d/%0b actual %h/%0d/%0d/%0b",
                             $time, want.out_byte, want.kind, want.error_code, want.last,
                             got.out_byte, got.kind, got.error_code, got.last);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    qsu_pkg::item_t     item         = '0;
    logic               result_stall = 1'b0;
    logic               item_stall;
    logic               result_valid;
    qsu_pkg::result_t   result;

    unescape_scoreboard sb;
    qsu_pkg::item_t     stim_q[$];
    bit [7:0]           lit_closer;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    int unsigned        items_sent;
    int unsigned        quiet_cycles = 0;

    quoted_string_unescaper_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_transfer(result);
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic qsu_pkg::item_t mk(logic [7:0] c, logic o, logic e);
        qsu_pkg::item_t r;
        r.ch          = c;
        r.opens       = o;
        r.end_of_text = e;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    task automatic queue_item(qsu_pkg::item_t it);
        stim_q.insert(stim_q.size(), it);
    endtask

    task automatic push_byte(logic [7:0] c);
        queue_item(mk(c, ($urandom_range(9) == 0), 1'b0));
    endtask

    task automatic push_end();
        queue_item(mk(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1));
    endtask

    task automatic add_u_escape();
        int unsigned cls;
        int unsigned n;
        int unsigned minn;
        bit [23:0]   cp;
        cls = $urandom_range(5);
        case (cls)
            0: cp = 24'($urandom_range(24'h7F));
            1: cp = 24'($urandom_range(24'h7FF, 24'h80));
            2: cp = 24'($urandom_range(24'hFFFF, 24'h800));
            3: cp = 24'($urandom_range(24'h10FFFF, 24'h10000));
            default: cp = 24'($urandom_range(24'hFFFFFF, 24'h110000));
        endcase
        for (minn = 1; minn < 6 && (cp >> (4 * minn)) != 0; minn++)
        begin
        end
        n = (cls == 5) ? 0 : $urandom_range(6, minn);
        push_byte(8'h5C);
        push_byte($urandom_range(1) ? "u" : "U");
        for (int i = n; i > 0; i--)
            push_byte(hex_char(4'(cp >> (4 * (i - 1)))));
    endtask

    task automatic add_piece();
        bit [7:0]    c;
        bit [7:0]    simple_set [6];
        int unsigned n;
        simple_set = '{"a", "b", "t", "n", "v", "f"};
        case ($urandom_range(9))
            0, 1, 2:
            begin
                if ($urandom_range(4) == 0)
                    c = 8'($urandom_range(255));
                else
                    c = 8'($urandom_range(8'h7E, 8'h20));
                if (c == lit_closer || c == 8'h5C || c == 8'h0A)
                    c = "A";
                push_byte(c);
            end
            3:
            begin
                push_byte(8'h5C);
                if ($urandom_range(2) == 0)
                    push_byte(8'($urandom_range(255)));
                else
                    push_byte(simple_set[$urandom_range(5)]);
            end
            4, 5:
            begin
                push_byte(8'h5C);
                n = $urandom_range(3, 1);
                for (int i = 0; i < n; i++)
                    push_byte(8'h30 + 8'($urandom_range(7)));
            end
            6:
            begin
                push_byte(8'h5C);
                push_byte($urandom_range(1) ? "x" : "X");
                n = $urandom_range(2);
                for (int i = 0; i < n; i++)
                    push_byte(hex_char(4'($urandom_range(15))));
            end
            default:
            begin
                add_u_escape();
            end
        endcase
    endtask

    task automatic build_literal();
        int unsigned pieces;
        case ($urandom_range(7))
            0, 1, 2, 3: lit_closer = 8'h22;
            4, 5: lit_closer = 8'h27;
            6: lit_closer = 8'($urandom_range(8'h7E, 8'h20));
            default: lit_closer = 8'($urandom_range(255));
        endcase
        if ($urandom_range(7) == 0)
        begin
            pieces = $urandom_range(4, 1);
            for (int i = 0; i < pieces; i++)
                queue_item(mk(8'($urandom_range(255)), 1'($urandom_range(1)),
                              ($urandom_range(3) == 0)));
        end
        queue_item(mk(lit_closer, 1'b1, 1'b0));
        pieces = $urandom_range(8, 1);
        for (int i = 0; i < pieces; i++)
            add_piece();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: push_byte(lit_closer);
            5: push_byte(8'h0A);
            6: push_end();
            7:
            begin
                push_byte(8'h5C);
                push_end();
            end
            8:
            begin
                push_byte(8'h5C);
                case ($urandom_range(2))
                    0: push_byte("x");
                    1: push_byte("u");
                    default: push_byte(8'h30 + 8'($urandom_range(7)));
                endcase
                push_end();
            end
            default:
            begin
                push_byte(8'h5C);
                push_byte("U");
                push_byte(hex_char(4'($urandom_range(15, 1))));
                for (int i = 0; i < 4; i++)
                    push_byte(hex_char(4'($urandom_range(15))));
                push_end();
            end
        endcase
    endtask

    task automatic send_all();
        qsu_pkg::item_t it;
        while (stim_q.size() > 0)
        begin
            it = stim_q.pop_front();
            while ($urandom_range(99) < send_idle_pct)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            item_valid <= 1'b1;
            item       <= it;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
            sb.note_transfer(it);
            items_sent++;
        end
    endtask

    initial
    begin
        sb            = new();
        send_idle_pct = 17;
        recv_idle_pct = 81;
        items_sent    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_item(mk("A", 1'b0, 1'b0));
        queue_item(mk(8'h00, 1'b0, 1'b1));
        queue_item(mk(8'h27, 1'b1, 1'b0));
        queue_item(mk("A", 1'b1, 1'b0));
        queue_item(mk(8'hFF, 1'b0, 1'b0));
        queue_item(mk(8'h00, 1'b0, 1'b0));
        queue_item(mk(8'h5C, 1'b0, 1'b0));
        queue_item(mk("f", 1'b0, 1'b0));
        queue_item(mk(8'h5C, 1'b0, 1'b0));
        queue_item(mk("7", 1'b0, 1'b0));
        queue_item(mk("7", 1'b0, 1'b0));
        queue_item(mk("7", 1'b0, 1'b0));
        queue_item(mk(8'h5C, 1'b0, 1'b0));
        queue_item(mk("x", 1'b0, 1'b0));
        queue_item(mk("g", 1'b0, 1'b0));
        queue_item(mk(8'h5C, 1'b0, 1'b0));
        queue_item(mk("u", 1'b0, 1'b0));
        queue_item(mk("D", 1'b0, 1'b0));
        queue_item(mk("8", 1'b0, 1'b0));
        queue_item(mk("0", 1'b0, 1'b0));
        queue_item(mk("0", 1'b0, 1'b0));
        queue_item(mk(8'h27, 1'b0, 1'b0));
        queue_item(mk(8'h22, 1'b1, 1'b0));
        queue_item(mk(8'h5C, 1'b0, 1'b0));
        queue_item(mk(8'hA5, 1'b1, 1'b1));
        send_all();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (items_sent < PHASE_ITEMS * (phase + 1))
            begin
                build_literal();
                send_all();
            end
        end
        item_valid <= 1'b0;

        while (sb.decoded_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.decoded_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== quoted_string_unescaper_core.f =====
rtl/core/qsu_pkg.sv
rtl/core/quoted_string_unescaper_core.sv
tb/sv/tb_quoted_string_unescaper_core.sv
